>>> rtl/hgdp_pkg.sv
// Types, item codes and fixed limits shared by the gamepad descriptor parser.
package hgdp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic              record_kind;
    logic [4:0]        target;
    logic [9:0]        bit_offset;
    logic [4:0]        field_width;
    logic signed [31:0] logical_min;
    logic signed [31:0] logical_max;
    logic              success;
    logic [7:0]        chosen_report_id;
    logic [10:0]       report_length_bits;
    logic              run_end;
  } out_item_t;

  // Global item set saved by push.
  typedef struct packed {
    logic [31:0] page;
    logic [31:0] lmin;
    logic [31:0] lmax;
    logic [5:0]  size;
    logic [7:0]  count;
    logic [7:0]  id;
  } glob_t;

  localparam int GLOB_W = $bits(glob_t);

  typedef enum logic [3:0] {
    S_IDLE, S_BYTE, S_EXEC, S_POP, S_INPOS, S_LRD, S_LEV,
    S_END, S_FIN0, S_FIN1, S_FLUSH
  } state_t;

  // Byte framing phases.
  localparam logic [2:0] PH_PREFIX    = 3'd0;
  localparam logic [2:0] PH_DATA      = 3'd1;
  localparam logic [2:0] PH_LONG_LEN  = 3'd2;
  localparam logic [2:0] PH_LONG_TAG  = 3'd3;
  localparam logic [2:0] PH_LONG_DATA = 3'd4;

  localparam logic [7:0] LONG_ITEM_PREFIX = 8'hFE;

  // Item types.
  localparam logic [1:0] TYPE_MAIN   = 2'd0;
  localparam logic [1:0] TYPE_GLOBAL = 2'd1;
  localparam logic [1:0] TYPE_LOCAL  = 2'd2;

  // Main tags.
  localparam logic [3:0] TAG_INPUT          = 4'd8;
  localparam logic [3:0] TAG_COLLECTION     = 4'd10;
  localparam logic [3:0] TAG_END_COLLECTION = 4'd12;
  // Global tags.
  localparam logic [3:0] TAG_USAGE_PAGE   = 4'd0;
  localparam logic [3:0] TAG_LOGICAL_MIN  = 4'd1;
  localparam logic [3:0] TAG_LOGICAL_MAX  = 4'd2;
  localparam logic [3:0] TAG_REPORT_SIZE  = 4'd7;
  localparam logic [3:0] TAG_REPORT_ID    = 4'd8;
  localparam logic [3:0] TAG_REPORT_COUNT = 4'd9;
  localparam logic [3:0] TAG_PUSH         = 4'd10;
  localparam logic [3:0] TAG_POP          = 4'd11;
  // Local tags.
  localparam logic [3:0] TAG_USAGE     = 4'd0;
  localparam logic [3:0] TAG_USAGE_MIN = 4'd1;
  localparam logic [3:0] TAG_USAGE_MAX = 4'd2;

  localparam logic [31:0] PAGE_GENERIC_DESKTOP = 32'd1;
  localparam logic [31:0] PAGE_BUTTON          = 32'd9;
  localparam logic [31:0] USAGE_JOYSTICK       = 32'd4;
  localparam logic [31:0] USAGE_GAMEPAD        = 32'd5;
  localparam logic [31:0] USAGE_X              = 32'h30;
  localparam logic [31:0] USAGE_Y              = 32'h31;
  localparam logic [31:0] USAGE_HAT            = 32'h39;
  localparam logic [31:0] BUTTON_FIRST         = 32'd1;
  localparam logic [31:0] BUTTON_LAST          = 32'd16;
  localparam logic [31:0] COLL_APPLICATION     = 32'd1;

  localparam logic [31:0] MAX_REPORT_SIZE  = 32'd32;
  localparam logic [31:0] MAX_REPORT_COUNT = 32'd128;
  localparam logic [31:0] MAX_REPORT_ID    = 32'd255;
  localparam logic [5:0]  MAX_MAP_SIZE     = 6'd16;
  localparam int          MAX_REPORT_BITS  = 1024;
  localparam logic [10:0] MAX_NESTING      = 11'd2047;

  localparam logic [4:0] TGT_X           = 5'd0;
  localparam logic [4:0] TGT_Y           = 5'd1;
  localparam logic [4:0] TGT_HAT         = 5'd2;
  localparam logic [4:0] TGT_BUTTON_BASE = 5'd2;
  localparam int         TGT_COUNT       = 19;

  localparam logic KIND_MAPPING = 1'b0;
  localparam logic KIND_FINAL   = 1'b1;

  // Data byte count of a short item from its size code.
  function automatic logic [2:0] item_len(input logic [1:0] sz);
    return (sz == 2'd3) ? 3'd4 : {1'b0, sz};
  endfunction

endpackage

>>> rtl/hgdp_ram.sv
// Generic simple dual-port RAM with registered read.
module hgdp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/hid_gamepad_descriptor_parser.sv
// Top level: HID report descriptor parser that locates a gamepad's fields.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------
//  in_     | in  | in_valid / in_stall  | in_item_t: descriptor byte, last flag
//  out_    | out | out_valid / out_stall| out_item_t: mapping or final record
//
// Flow: one byte at a time. A plain byte passes the accept, frame, wrap-up
// and flush states; an item that completes adds an execute state, a pop or
// an Input item a further state, and a mapped Input item a usage RAM read,
// then evaluate, per report field. The final byte adds a report length lookup.
// Reset: rst_n synchronous; the last byte also returns the parser state to reset.
// Report-id positions use per-entry valid bits, so no clearing pass is run.
// Stalls: a result sits in the output register while the next one is
// prepared in a one-deep staging register; the parser waits only when both
// are full.
module hid_gamepad_descriptor_parser
  import hgdp_pkg::*;
#(
  parameter int MAX_DESCRIPTOR_BYTES = 1024,
  parameter int GLOBAL_STACK_DEPTH   = 8,
  parameter int USAGE_SLOTS          = 32,
  parameter int REPORT_ID_COUNT      = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int BCW = $clog2(MAX_DESCRIPTOR_BYTES + 1);
  localparam int SLW = $clog2(GLOBAL_STACK_DEPTH + 1);
  localparam int SAW = (GLOBAL_STACK_DEPTH > 1) ? $clog2(GLOBAL_STACK_DEPTH) : 1;
  localparam int UFW = $clog2(USAGE_SLOTS + 1);
  localparam int UAW = $clog2(USAGE_SLOTS);
  localparam int IDW = (REPORT_ID_COUNT > 1) ? $clog2(REPORT_ID_COUNT) : 1;

  localparam logic [BCW-1:0] BYTE_LIMIT = BCW'(MAX_DESCRIPTOR_BYTES);
  localparam logic [SLW-1:0] STACK_FULL = SLW'(GLOBAL_STACK_DEPTH);
  localparam logic [UFW-1:0] USAGE_FULL = UFW'(USAGE_SLOTS);
  localparam logic [31:0]    ID_LIMIT   = 32'(REPORT_ID_COUNT);

  state_t state_r, state_nxt;

  logic [7:0]     byte_r, byte_nxt;
  logic           last_r, last_nxt;
  logic [BCW-1:0] byte_cnt_r, byte_cnt_nxt;
  logic [2:0]     phase_r, phase_nxt;
  logic [7:0]     prefix_r, prefix_nxt;
  logic [31:0]    data_r, data_nxt;
  logic [7:0]     pending_r, pending_nxt;
  logic           failed_r, failed_nxt;

  logic [31:0]    page_r, page_nxt;
  logic [31:0]    lmin_r, lmin_nxt;
  logic [31:0]    lmax_r, lmax_nxt;
  logic [5:0]     size_r, size_nxt;
  logic [7:0]     count_r, count_nxt;
  logic [7:0]     id_r, id_nxt;
  logic [SLW-1:0] level_r, level_nxt;

  logic [UFW-1:0] fill_r, fill_nxt;
  logic [31:0]    usage0_r, usage0_nxt;
  logic [31:0]    rlow_r, rlow_nxt;
  logic [31:0]    rhigh_r, rhigh_nxt;
  logic           rseen_r, rseen_nxt;

  logic [REPORT_ID_COUNT-1:0] bp_vld_r, bp_vld_nxt;
  logic [10:0]    depth_r, depth_nxt;
  logic           in_gp_r, in_gp_nxt;
  logic           found_r, found_nxt;
  logic           picked_r, picked_nxt;
  logic [7:0]     pick_id_r, pick_id_nxt;
  logic [TGT_COUNT-1:0] mask_r, mask_nxt;

  logic [10:0]    off_r, off_nxt;
  logic [6:0]     i_r, i_nxt;

  logic           stg_vld_r, stg_vld_nxt;
  out_item_t      stg_r, stg_nxt;
  logic           out_valid_r, out_valid_nxt;
  out_item_t      out_r, out_nxt;

  logic           clear_all;

  // Memories
  logic              stk_we;
  logic [SAW-1:0]    stk_waddr, stk_raddr;
  glob_t             stk_wdata;
  logic [GLOB_W-1:0] stk_rdata;
  glob_t             stk_rd;
  logic              use_we;
  logic [UAW-1:0]    use_waddr, use_raddr;
  logic [31:0]       use_wdata, use_rdata;
  logic              bp_we;
  logic [IDW-1:0]    bp_waddr, bp_raddr;
  logic [10:0]       bp_wdata, bp_rdata;

  // Decode
  logic [2:0]     blen, plen, didx;
  logic [1:0]     ityp;
  logic [3:0]     itag;
  logic [31:0]    sv, coll_usage;
  logic           byte_limit, item_done, is_push, is_pop, is_input;
  logic [10:0]    pos, len_fin;
  logic [13:0]    bits;
  logic [14:0]    pos_end;
  logic           too_long, map_ok;
  logic [7:0]     i_ext;
  logic           in_list, in_rng, last_iter;
  logic [31:0]    rng_u, u;
  logic [UFW-1:0] fill_m1;
  logic [SLW-1:0] level_m1;
  logic [4:0]     tgt;
  logic           tgt_ok, hit, fin_ok;
  logic           out_free, emit, push_wait, out_load, out_end;
  out_item_t      map_rec, fin_rec;

  assign stk_rd = glob_t'(stk_rdata);

  hgdp_ram #(.WIDTH(GLOB_W), .DEPTH(GLOBAL_STACK_DEPTH)) u_stack_ram (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  hgdp_ram #(.WIDTH(32), .DEPTH(USAGE_SLOTS)) u_usage_ram (
    .clk(clk), .we(use_we), .waddr(use_waddr), .wdata(use_wdata),
    .raddr(use_raddr), .rdata(use_rdata)
  );

  hgdp_ram #(.WIDTH(11), .DEPTH(REPORT_ID_COUNT)) u_bitpos_ram (
    .clk(clk), .we(bp_we), .waddr(bp_waddr), .wdata(bp_wdata),
    .raddr(bp_raddr), .rdata(bp_rdata)
  );

  always_comb begin
    blen  = item_len(byte_r[1:0]);
    plen  = item_len(prefix_r[1:0]);
    didx  = plen - pending_r[2:0];
    ityp  = prefix_r[3:2];
    itag  = prefix_r[7:4];
    case (plen)
      3'd1:    sv = {{24{data_r[7]}}, data_r[7:0]};
      3'd2:    sv = {{16{data_r[15]}}, data_r[15:0]};
      default: sv = data_r;
    endcase
    coll_usage = (fill_r != '0) ? usage0_r : rlow_r;

    byte_limit = byte_cnt_r >= BYTE_LIMIT;
    item_done  = (phase_r == PH_PREFIX && byte_r != LONG_ITEM_PREFIX && blen == 3'd0) ||
                 (phase_r == PH_DATA && pending_r == 8'd1);
    is_push  = ityp == TYPE_GLOBAL && itag == TAG_PUSH && level_r < STACK_FULL;
    is_pop   = ityp == TYPE_GLOBAL && itag == TAG_POP && level_r != '0;
    is_input = ityp == TYPE_MAIN && itag == TAG_INPUT;
    level_m1 = level_r - 1'b1;

    // Input item placement
    pos      = bp_vld_r[id_r[IDW-1:0]] ? bp_rdata : 11'd0;
    bits     = 14'(size_r) * 14'(count_r);
    pos_end  = 15'(pos) + 15'(bits);
    too_long = bits > 14'(MAX_REPORT_BITS) || pos_end > 15'(MAX_REPORT_BITS);
    map_ok   = in_gp_r && !data_r[0] && data_r[1] && size_r != '0 &&
               size_r <= MAX_MAP_SIZE && (!picked_r || id_r == pick_id_r);

    // Usage for field i: list entry, then range, then last list entry
    i_ext     = {1'b0, i_r};
    fill_m1   = fill_r - 1'b1;
    in_list   = i_ext < 8'(fill_r);
    rng_u     = rlow_r + 32'(i_r);
    in_rng    = rseen_r && rng_u <= rhigh_r;
    use_raddr = in_list ? i_r[UAW-1:0] : fill_m1[UAW-1:0];
    if (in_list) begin
      u = use_rdata;
    end else if (in_rng) begin
      u = rng_u;
    end else if (fill_r != '0) begin
      u = use_rdata;
    end else begin
      u = '0;
    end
    last_iter = (i_ext + 8'd1) == count_r;

    tgt    = TGT_X;
    tgt_ok = 1'b0;
    if (page_r == PAGE_GENERIC_DESKTOP) begin
      if (u == USAGE_X) begin
        tgt = TGT_X;   tgt_ok = 1'b1;
      end
      if (u == USAGE_Y) begin
        tgt = TGT_Y;   tgt_ok = 1'b1;
      end
      if (u == USAGE_HAT) begin
        tgt = TGT_HAT; tgt_ok = 1'b1;
      end
    end else if (page_r == PAGE_BUTTON && u inside {[BUTTON_FIRST:BUTTON_LAST]}) begin
      tgt    = u[4:0] + TGT_BUTTON_BASE;
      tgt_ok = 1'b1;
    end
    hit = tgt_ok && !mask_r[tgt];

    len_fin = bp_vld_r[pick_id_r[IDW-1:0]] ? bp_rdata : 11'd0;
    fin_ok  = !failed_r && phase_r == PH_PREFIX && found_r && picked_r &&
              depth_r == '0 && level_r == '0 && mask_r[2:0] != 3'd0 && len_fin != '0;

    map_rec             = '0;
    map_rec.record_kind = KIND_MAPPING;
    map_rec.target      = tgt;
    map_rec.bit_offset  = off_r[9:0];
    map_rec.field_width = size_r[4:0];
    map_rec.logical_min = lmin_r;
    map_rec.logical_max = lmax_r;

    fin_rec             = '0;
    fin_rec.record_kind = KIND_FINAL;
    if (fin_ok) begin
      fin_rec.success            = 1'b1;
      fin_rec.chosen_report_id   = pick_id_r;
      fin_rec.report_length_bits = len_fin;
    end

    out_free  = !out_valid_r || !out_stall;
    emit      = (state_r == S_LEV && hit) || state_r == S_FIN1;
    push_wait = emit && stg_vld_r && !out_free;
    out_end   = state_r == S_FLUSH && stg_vld_r && out_free;
    out_load  = (emit && stg_vld_r && out_free) || out_end;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_BYTE;
      S_BYTE: begin
        if (failed_r || byte_limit) state_nxt = S_END;
        else if (item_done)         state_nxt = S_EXEC;
        else                        state_nxt = S_END;
      end
      S_EXEC: begin
        if (is_pop)        state_nxt = S_POP;
        else if (is_input) state_nxt = S_INPOS;
        else               state_nxt = S_END;
      end
      S_POP:   state_nxt = S_END;
      S_INPOS: begin
        if (!too_long && map_ok && count_r != '0) state_nxt = S_LRD;
        else                                      state_nxt = S_END;
      end
      S_LRD:   state_nxt = S_LEV;
      S_LEV: begin
        if (!push_wait) state_nxt = last_iter ? S_END : S_LRD;
      end
      S_END:   state_nxt = last_r ? S_FIN0 : S_FLUSH;
      S_FIN0:  state_nxt = S_FIN1;
      S_FIN1:  if (!push_wait) state_nxt = S_FLUSH;
      S_FLUSH: if (!stg_vld_r || out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    byte_nxt     = byte_r;
    last_nxt     = last_r;
    byte_cnt_nxt = byte_cnt_r;
    phase_nxt    = phase_r;
    prefix_nxt   = prefix_r;
    data_nxt     = data_r;
    pending_nxt  = pending_r;
    failed_nxt   = failed_r;
    page_nxt     = page_r;
    lmin_nxt     = lmin_r;
    lmax_nxt     = lmax_r;
    size_nxt     = size_r;
    count_nxt    = count_r;
    id_nxt       = id_r;
    level_nxt    = level_r;
    fill_nxt     = fill_r;
    usage0_nxt   = usage0_r;
    rlow_nxt     = rlow_r;
    rhigh_nxt    = rhigh_r;
    rseen_nxt    = rseen_r;
    bp_vld_nxt   = bp_vld_r;
    depth_nxt    = depth_r;
    in_gp_nxt    = in_gp_r;
    found_nxt    = found_r;
    picked_nxt   = picked_r;
    pick_id_nxt  = pick_id_r;
    mask_nxt     = mask_r;
    off_nxt      = off_r;
    i_nxt        = i_r;
    stg_vld_nxt  = stg_vld_r;
    stg_nxt      = stg_r;
    clear_all    = 1'b0;

    stk_we    = 1'b0;
    stk_waddr = level_r[SAW-1:0];
    stk_raddr = level_m1[SAW-1:0];
    stk_wdata = '{page: page_r, lmin: lmin_r, lmax: lmax_r,
                  size: size_r, count: count_r, id: id_r};
    use_we    = 1'b0;
    use_waddr = fill_r[UAW-1:0];
    use_wdata = data_r;
    bp_we     = 1'b0;
    bp_waddr  = id_r[IDW-1:0];
    bp_wdata  = pos_end[10:0];
    // keep the picked id's entry on the read port while the final record waits
    bp_raddr  = (state_r == S_FIN0 || state_r == S_FIN1) ? pick_id_r[IDW-1:0] :
                                                           id_r[IDW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          byte_nxt = in_data.data_byte;
          last_nxt = in_data.last_byte;
        end
      end

      S_BYTE: begin
        if (!failed_r) begin
          if (byte_limit) begin
            failed_nxt = 1'b1;
          end else begin
            byte_cnt_nxt = byte_cnt_r + 1'b1;
            case (phase_r)
              PH_PREFIX: begin
                if (byte_r == LONG_ITEM_PREFIX) begin
                  phase_nxt = PH_LONG_LEN;
                end else begin
                  prefix_nxt  = byte_r;
                  data_nxt    = '0;
                  pending_nxt = 8'(blen);
                  if (blen != 3'd0) phase_nxt = PH_DATA;
                end
              end
              PH_DATA: begin
                data_nxt    = data_r | (32'(byte_r) << {didx[1:0], 3'b000});
                pending_nxt = pending_r - 8'd1;
                if (pending_r == 8'd1) phase_nxt = PH_PREFIX;
              end
              PH_LONG_LEN: begin
                pending_nxt = byte_r;
                phase_nxt   = PH_LONG_TAG;
              end
              PH_LONG_TAG: begin
                phase_nxt = (pending_r != '0) ? PH_LONG_DATA : PH_PREFIX;
              end
              default: begin
                if (pending_r != '0) pending_nxt = pending_r - 8'd1;
                if (pending_r <= 8'd1) phase_nxt = PH_PREFIX;
              end
            endcase
          end
        end
      end

      S_EXEC: begin
        case (ityp)
          TYPE_GLOBAL: begin
            case (itag)
              TAG_USAGE_PAGE:  page_nxt = data_r;
              TAG_LOGICAL_MIN: lmin_nxt = sv;
              TAG_LOGICAL_MAX: lmax_nxt = lmin_r[31] ? sv : data_r;
              TAG_REPORT_SIZE: begin
                if (data_r > MAX_REPORT_SIZE) failed_nxt = 1'b1;
                else                          size_nxt   = data_r[5:0];
              end
              TAG_REPORT_ID: begin
                if (data_r == '0 || data_r > MAX_REPORT_ID || data_r >= ID_LIMIT)
                  failed_nxt = 1'b1;
                else
                  id_nxt = data_r[7:0];
              end
              TAG_REPORT_COUNT: begin
                if (data_r > MAX_REPORT_COUNT) failed_nxt = 1'b1;
                else                           count_nxt  = data_r[7:0];
              end
              TAG_PUSH: begin
                if (is_push) begin
                  stk_we    = 1'b1;
                  level_nxt = level_r + 1'b1;
                end else begin
                  failed_nxt = 1'b1;
                end
              end
              TAG_POP: if (!is_pop) failed_nxt = 1'b1;
              default: ;
            endcase
          end
          TYPE_LOCAL: begin
            case (itag)
              TAG_USAGE: begin
                if (fill_r < USAGE_FULL) begin
                  use_we   = 1'b1;
                  fill_nxt = fill_r + 1'b1;
                  if (fill_r == '0) usage0_nxt = data_r;
                end
              end
              TAG_USAGE_MIN: begin
                rlow_nxt  = data_r;
                rseen_nxt = 1'b1;
              end
              TAG_USAGE_MAX: rhigh_nxt = data_r;
              default: ;
            endcase
          end
          TYPE_MAIN: begin
            case (itag)
              TAG_COLLECTION: begin
                if (depth_r >= MAX_NESTING) begin
                  failed_nxt = 1'b1;
                end else begin
                  if (depth_r == '0 && data_r == COLL_APPLICATION &&
                      page_r == PAGE_GENERIC_DESKTOP && !found_r &&
                      coll_usage inside {USAGE_JOYSTICK, USAGE_GAMEPAD}) begin
                    in_gp_nxt = 1'b1;
                    found_nxt = 1'b1;
                  end
                  depth_nxt = depth_r + 1'b1;
                  fill_nxt  = '0;
                  rlow_nxt  = '0;
                  rhigh_nxt = '0;
                  rseen_nxt = 1'b0;
                end
              end
              TAG_END_COLLECTION: begin
                if (depth_r == '0) begin
                  failed_nxt = 1'b1;
                end else begin
                  if (in_gp_r && depth_r == 11'd1) in_gp_nxt = 1'b0;
                  depth_nxt = depth_r - 1'b1;
                  fill_nxt  = '0;
                  rlow_nxt  = '0;
                  rhigh_nxt = '0;
                  rseen_nxt = 1'b0;
                end
              end
              TAG_INPUT: ;
              default: begin
                fill_nxt  = '0;
                rlow_nxt  = '0;
                rhigh_nxt = '0;
                rseen_nxt = 1'b0;
              end
            endcase
          end
          default: ;  // reserved type, locals kept
        endcase
      end

      S_POP: begin
        level_nxt = level_m1;
        page_nxt  = stk_rd.page;
        lmin_nxt  = stk_rd.lmin;
        lmax_nxt  = stk_rd.lmax;
        size_nxt  = stk_rd.size;
        count_nxt = stk_rd.count;
        id_nxt    = stk_rd.id;
      end

      S_INPOS: begin
        if (too_long) begin
          failed_nxt = 1'b1;
        end else begin
          bp_we                      = 1'b1;
          bp_vld_nxt[id_r[IDW-1:0]] = 1'b1;
          off_nxt                    = pos;
          i_nxt                      = '0;
          if (map_ok && !picked_r) begin
            picked_nxt  = 1'b1;
            pick_id_nxt = id_r;
          end
          if (!(map_ok && count_r != '0)) begin
            fill_nxt  = '0;
            rlow_nxt  = '0;
            rhigh_nxt = '0;
            rseen_nxt = 1'b0;
          end
        end
      end

      S_LEV: begin
        if (!push_wait) begin
          if (hit) begin
            mask_nxt[tgt] = 1'b1;
            stg_nxt       = map_rec;
            stg_vld_nxt   = 1'b1;
          end
          i_nxt   = i_r + 1'b1;
          off_nxt = off_r + 11'(size_r);
          if (last_iter) begin
            fill_nxt  = '0;
            rlow_nxt  = '0;
            rhigh_nxt = '0;
            rseen_nxt = 1'b0;
          end
        end
      end

      S_FIN1: begin
        if (!push_wait) begin
          stg_nxt     = fin_rec;
          stg_vld_nxt = 1'b1;
        end
      end

      S_FLUSH: begin
        if (!stg_vld_r || out_free) begin
          stg_vld_nxt = 1'b0;
          clear_all   = last_r;
        end
      end

      default: ;
    endcase
  end

  // Output register
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_nxt         = stg_r;
      out_nxt.run_end = out_end;
      out_valid_nxt   = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Parser state; the final byte returns it to reset
  always_ff @(posedge clk) begin
    if (!rst_n || clear_all) begin
      byte_cnt_r <= '0;
      phase_r    <= PH_PREFIX;
      prefix_r   <= '0;
      data_r     <= '0;
      pending_r  <= '0;
      failed_r   <= 1'b0;
      page_r     <= '0;
      lmin_r     <= '0;
      lmax_r     <= '0;
      size_r     <= '0;
      count_r    <= '0;
      id_r       <= '0;
      level_r    <= '0;
      fill_r     <= '0;
      usage0_r   <= '0;
      rlow_r     <= '0;
      rhigh_r    <= '0;
      rseen_r    <= 1'b0;
      bp_vld_r   <= '0;
      depth_r    <= '0;
      in_gp_r    <= 1'b0;
      found_r    <= 1'b0;
      picked_r   <= 1'b0;
      pick_id_r  <= '0;
      mask_r     <= '0;
      stg_vld_r  <= 1'b0;
    end else begin
      byte_cnt_r <= byte_cnt_nxt;
      phase_r    <= phase_nxt;
      prefix_r   <= prefix_nxt;
      data_r     <= data_nxt;
      pending_r  <= pending_nxt;
      failed_r   <= failed_nxt;
      page_r     <= page_nxt;
      lmin_r     <= lmin_nxt;
      lmax_r     <= lmax_nxt;
      size_r     <= size_nxt;
      count_r    <= count_nxt;
      id_r       <= id_nxt;
      level_r    <= level_nxt;
      fill_r     <= fill_nxt;
      usage0_r   <= usage0_nxt;
      rlow_r     <= rlow_nxt;
      rhigh_r    <= rhigh_nxt;
      rseen_r    <= rseen_nxt;
      bp_vld_r   <= bp_vld_nxt;
      depth_r    <= depth_nxt;
      in_gp_r    <= in_gp_nxt;
      found_r    <= found_nxt;
      picked_r   <= picked_nxt;
      pick_id_r  <= pick_id_nxt;
      mask_r     <= mask_nxt;
      stg_vld_r  <= stg_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    off_r  <= off_nxt;
    i_r    <= i_nxt;
    stg_r  <= stg_nxt;
    out_r  <= out_nxt;
  end

  // Checks
  a_push_level: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && is_push) |=> (level_r == $past(level_r) + 1'b1))
    else $error("stack level did not advance on push");

  a_mask_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_FLUSH) |=> ((mask_r & $past(mask_r)) == $past(mask_r)))
    else $error("mapped target lost within a descriptor");

  a_final_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.record_kind == KIND_FINAL) |-> out_data.run_end)
    else $error("final record without run end");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !stg_vld_r)
    else $error("staged result left behind when taking a new item");

endmodule
